>>> src/nsfc_pkg.sv
// Shared types, character codes and helpers for the NMEA sentence framer and checker.
package nsfc_pkg;

    localparam int LINE_LIMIT  = 128;
    localparam int FIELD_LIMIT = 32;
    localparam int LEN_W       = 8;
    localparam int FIELD_W     = 6;
    localparam int CNT_W       = 32;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [23:0] ID_GGA = 24'h474741;
    localparam logic [23:0] ID_RMC = 24'h524D43;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NO_SUM   = 2'd1,
        ST_BAD_HEX  = 2'd2,
        ST_MISMATCH = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        KIND_OTHER = 2'd0,
        KIND_GGA   = 2'd1,
        KIND_RMC   = 2'd2
    } kind_t;

    typedef struct packed {
        logic       bad;
        logic [3:0] nibble;
    } hex_t;

    // Line-end event from the tracker to the result stage.
    typedef struct packed {
        logic               fire;
        status_t            status;
        kind_t              kind;
        logic [FIELD_W-1:0] fields;
        logic [7:0]         sum;
    } line_evt_t;

    function automatic hex_t hex_decode(input logic [7:0] c);
        hex_t h;
        h.bad    = 1'b0;
        h.nibble = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.nibble = c[3:0];
        end
        else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
            h.nibble = c[3:0] + 4'd9;
        end
        else begin
            h.bad = 1'b1;
        end
        return h;
    endfunction

endpackage

>>> src/nsfc_if.sv
// Valid/ready channel interfaces for received bytes and sentence results.
interface nsfc_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nsfc_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [1:0]  sentence_kind;
    logic [5:0]  field_total;
    logic [7:0]  computed_sum;
    logic [31:0] used_sentences;
    logic [31:0] bad_sum_total;

    modport source (output valid, output status, output sentence_kind, output field_total,
                    output computed_sum, output used_sentences, output bad_sum_total,
                    input ready);
    modport sink   (input valid, input status, input sentence_kind, input field_total,
                    input computed_sum, input used_sentences, input bad_sum_total,
                    output ready);
endinterface

>>> src/nsfc_line_tracker.sv
// Per-line framing state: length, checksum, star capture, field count and id tail.
module nsfc_line_tracker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          rx_byte,
    output nsfc_pkg::line_evt_t evt
);

    logic                        inside_reg, inside_next;
    logic                        drop_reg, drop_next;
    logic [nsfc_pkg::LEN_W-1:0]  len_reg, len_next;
    logic                        star_reg, star_next;
    logic [1:0]                  after_cnt_reg, after_cnt_next;
    logic [7:0]                  sum_reg, sum_next;
    logic [7:0]                  hi_reg, hi_next;
    logic [7:0]                  lo_reg, lo_next;
    logic                        ffc_reg, ffc_next;
    logic [23:0]                 id_reg, id_next;
    logic [1:0]                  idlen_reg, idlen_next;
    logic [nsfc_pkg::FIELD_W-1:0] fcnt_reg, fcnt_next;

    logic             clear_line;
    nsfc_pkg::hex_t   hi_hex, lo_hex;
    nsfc_pkg::status_t status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inside_reg    <= 1'b0;
            drop_reg      <= 1'b0;
            len_reg       <= '0;
            star_reg      <= 1'b0;
            after_cnt_reg <= 2'd0;
            sum_reg       <= 8'd0;
            hi_reg        <= 8'd0;
            lo_reg        <= 8'd0;
            ffc_reg       <= 1'b0;
            id_reg        <= 24'd0;
            idlen_reg     <= 2'd0;
            fcnt_reg      <= nsfc_pkg::FIELD_W'(1);
        end
        else
        begin
            inside_reg    <= inside_next;
            drop_reg      <= drop_next;
            len_reg       <= len_next;
            star_reg      <= star_next;
            after_cnt_reg <= after_cnt_next;
            sum_reg       <= sum_next;
            hi_reg        <= hi_next;
            lo_reg        <= lo_next;
            ffc_reg       <= ffc_next;
            id_reg        <= id_next;
            idlen_reg     <= idlen_next;
            fcnt_reg      <= fcnt_next;
        end
    end

    // Verdict on the line held so far; only used when a CR/LF closes it.
    always_comb
    begin
        hi_hex = nsfc_pkg::hex_decode(hi_reg);
        lo_hex = nsfc_pkg::hex_decode(lo_reg);
        if (!star_reg || after_cnt_reg != 2'd2)
            status = nsfc_pkg::ST_NO_SUM;
        else if (hi_hex.bad || lo_hex.bad)
            status = nsfc_pkg::ST_BAD_HEX;
        else if ({hi_hex.nibble, lo_hex.nibble} != sum_reg)
            status = nsfc_pkg::ST_MISMATCH;
        else
            status = nsfc_pkg::ST_OK;
    end

    always_comb
    begin
        inside_next    = inside_reg;
        drop_next      = drop_reg;
        len_next       = len_reg;
        star_next      = star_reg;
        after_cnt_next = after_cnt_reg;
        sum_next       = sum_reg;
        hi_next        = hi_reg;
        lo_next        = lo_reg;
        ffc_next       = ffc_reg;
        id_next        = id_reg;
        idlen_next     = idlen_reg;
        fcnt_next      = fcnt_reg;
        clear_line     = 1'b0;

        evt.fire   = 1'b0;
        evt.status = status;
        evt.kind   = nsfc_pkg::KIND_OTHER;
        evt.fields = '0;
        evt.sum    = (status == nsfc_pkg::ST_NO_SUM) ? 8'd0 : sum_reg;
        if (status == nsfc_pkg::ST_OK)
        begin
            evt.fields = fcnt_reg;
            if (idlen_reg == 2'd3 && id_reg == nsfc_pkg::ID_GGA)
                evt.kind = nsfc_pkg::KIND_GGA;
            else if (idlen_reg == 2'd3 && id_reg == nsfc_pkg::ID_RMC)
                evt.kind = nsfc_pkg::KIND_RMC;
        end

        if (take)
        begin
            if (rx_byte == nsfc_pkg::CH_DOLLAR)
            begin
                inside_next = 1'b1;
                clear_line  = 1'b1;
            end
            else if (inside_reg && rx_byte != nsfc_pkg::CH_CR && rx_byte != nsfc_pkg::CH_LF)
            begin
                if (len_reg >= nsfc_pkg::LEN_W'(nsfc_pkg::LINE_LIMIT))
                begin
                    drop_next = 1'b1;
                end
                else
                begin
                    len_next = len_reg + 1'b1;
                    if (star_reg)
                    begin
                        // two checksum chars, anything after is only counted
                        if (after_cnt_reg == 2'd0)
                        begin
                            hi_next        = rx_byte;
                            after_cnt_next = 2'd1;
                        end
                        else if (after_cnt_reg == 2'd1)
                        begin
                            lo_next        = rx_byte;
                            after_cnt_next = 2'd2;
                        end
                    end
                    else if (rx_byte == nsfc_pkg::CH_STAR)
                    begin
                        star_next = 1'b1;
                        ffc_next  = 1'b1;
                    end
                    else
                    begin
                        sum_next = sum_reg ^ rx_byte;
                        if (rx_byte == nsfc_pkg::CH_COMMA)
                        begin
                            ffc_next = 1'b1;
                            if (fcnt_reg < nsfc_pkg::FIELD_W'(nsfc_pkg::FIELD_LIMIT))
                                fcnt_next = fcnt_reg + 1'b1;
                        end
                        else if (!ffc_reg)
                        begin
                            id_next = {id_reg[15:0], rx_byte};
                            if (idlen_reg != 2'd3)
                                idlen_next = idlen_reg + 1'b1;
                        end
                    end
                end
            end
            else if (inside_reg)
            begin
                inside_next = 1'b0;
                clear_line  = 1'b1;
                evt.fire    = !drop_reg && len_reg != '0;
            end
        end

        if (clear_line)
        begin
            drop_next      = 1'b0;
            len_next       = '0;
            star_next      = 1'b0;
            after_cnt_next = 2'd0;
            sum_next       = 8'd0;
            hi_next        = 8'd0;
            lo_next        = 8'd0;
            ffc_next       = 1'b0;
            id_next        = 24'd0;
            idlen_next     = 2'd0;
            fcnt_next      = nsfc_pkg::FIELD_W'(1);
        end
    end

    a_len_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= nsfc_pkg::LEN_W'(nsfc_pkg::LINE_LIMIT))
        else $error("line length beyond limit");

    a_fcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        fcnt_reg != '0 && fcnt_reg <= nsfc_pkg::FIELD_W'(nsfc_pkg::FIELD_LIMIT))
        else $error("field counter out of range");

    a_line_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !inside_reg |-> len_reg == '0 && !drop_reg && !star_reg)
        else $error("line state left over outside a sentence");

endmodule

>>> src/nmea_sentence_framer_checker.sv
// Top level: byte input register, line tracker and registered sentence result.
//
//   channel | modport | beat                         | handshake
//   rx      | sink    | rx_byte                      | valid & ready
//   res     | source  | status, kind, fields, counts | valid & ready
//
// One byte per cycle sustained while results are taken; a CR/LF byte passes the byte
// input register, then its result is held in the result register.
// rst_n (async, active low) clears framing state and both wrapping counters.
// A held result that is not taken stalls byte processing; rx stays ready
// while its input register is empty or draining.
module nmea_sentence_framer_checker (
    input  logic                 clk,
    input  logic                 rst_n,
    nsfc_byte_if.sink            rx,
    nsfc_result_if.source        res
);

    logic                        byte_vld_reg;
    logic [7:0]                  byte_reg;
    logic                        res_vld_reg, res_vld_next;
    logic [1:0]                  status_reg;
    logic [1:0]                  kind_reg;
    logic [nsfc_pkg::FIELD_W-1:0] fields_reg;
    logic [7:0]                  sum_reg;
    logic [nsfc_pkg::CNT_W-1:0]  good_reg, good_next;
    logic [nsfc_pkg::CNT_W-1:0]  bad_reg, bad_next;

    logic                 go;
    logic                 take;
    nsfc_pkg::line_evt_t  evt;

    assign go       = !res_vld_reg || res.ready;
    assign take     = byte_vld_reg && go;
    assign rx.ready = !byte_vld_reg || go;

    nsfc_line_tracker u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .take    (take),
        .rx_byte (byte_reg),
        .evt     (evt)
    );

    always_comb
    begin
        good_next    = good_reg;
        bad_next     = bad_reg;
        res_vld_next = res_vld_reg && !res.ready;
        if (take && evt.fire)
        begin
            res_vld_next = 1'b1;
            if (evt.status != nsfc_pkg::ST_OK)
                bad_next = bad_reg + 1'b1;
            else if (evt.kind != nsfc_pkg::KIND_OTHER)
                good_next = good_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            res_vld_reg  <= 1'b0;
            good_reg     <= '0;
            bad_reg      <= '0;
        end
        else
        begin
            if (rx.ready)
                byte_vld_reg <= rx.valid;
            res_vld_reg <= res_vld_next;
            good_reg    <= good_next;
            bad_reg     <= bad_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.ready && rx.valid)
            byte_reg <= rx.rx_byte;
        if (take && evt.fire)
        begin
            status_reg <= evt.status;
            kind_reg   <= evt.kind;
            fields_reg <= evt.fields;
            sum_reg    <= evt.sum;
        end
    end

    assign res.valid          = res_vld_reg;
    assign res.status         = status_reg;
    assign res.sentence_kind  = kind_reg;
    assign res.field_total    = fields_reg;
    assign res.computed_sum   = sum_reg;
    assign res.used_sentences = good_reg;
    assign res.bad_sum_total  = bad_reg;

    a_fail_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && status_reg != nsfc_pkg::ST_OK |->
            kind_reg == nsfc_pkg::KIND_OTHER && fields_reg == '0)
        else $error("failed line carries kind or field count");

    a_ok_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && status_reg == nsfc_pkg::ST_OK |-> fields_reg != '0)
        else $error("good line with zero fields");

    a_counters_one_step: assert property (@(posedge clk) disable iff (!rst_n)
        !(take && evt.fire) |=> $stable(good_reg) && $stable(bad_reg))
        else $error("counter moved without a line end");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        res_vld_reg && !res.ready |-> !take)
        else $error("byte processed while result held");

endmodule
